// File: rtl/csgt_pkg.sv
// Shared types and codes for the conveyor sort gate tracker.
// Used by conveyor_sort_gate_tracker_unit and sim/testbench.sv; depends on nothing.
package csgt_pkg;

  typedef enum logic [1:0] {
    CMD_REPORT = 2'd0,
    CMD_CLICK  = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    COL_WHITE = 2'd0,
    COL_RED   = 2'd1,
    COL_BLUE  = 2'd2
  } color_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  localparam logic [1:0] REG_WHITE_DIST = 2'd0;
  localparam logic [1:0] REG_RED_DIST   = 2'd1;
  localparam logic [1:0] REG_BLUE_DIST  = 2'd2;
  localparam logic [1:0] REG_HOLD_TIME  = 2'd3;

  localparam logic [15:0] WHITE_DIST_RST = 16'd50;
  localparam logic [15:0] RED_DIST_RST   = 16'd100;
  localparam logic [15:0] BLUE_DIST_RST  = 16'd150;
  localparam logic [15:0] HOLD_TIME_RST  = 16'd1000;

  localparam int unsigned NUM_GATES = 3;

  typedef struct packed {
    color_e      color;
    logic [31:0] target;
  } entry_t;

endpackage

// File: rtl/conveyor_sort_gate_tracker_unit.sv
// Conveyor sort gate tracker: puck queue in a one-port-read/one-port-write RAM.
// After each input transaction the queue is scanned through the single read port, and
// the result is then registered; it waits while the result register holds a result
// not yet taken on m_axis_tready. A new input transaction is accepted only in idle,
// once the previous result has been loaded into the result register.
// Reset: control, click count, gates, timers and registers cleared or preset;
// the queue RAM is not cleared, entries beyond the fill count are never read.
module conveyor_sort_gate_tracker_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] color, rest zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] accepted, [1] white_gate_open,
                                      // [2] red_gate_open, [3] blue_gate_open,
                                      // [6:4] released_mask, [11:7] pucks_tracked
);
  import csgt_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  state_e      state_q, state_d;
  logic [31:0] click_q, click_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] wr_ptr_q, wr_ptr_d;
  logic        rvld_q, rvld_d;
  logic [2:0]  rel_q, rel_d;
  logic        acc_q, acc_d;
  logic [2:0]  gate_drv_q, gate_drv_d;
  logic [15:0] gate_tmr_q [NUM_GATES];
  logic [15:0] gate_tmr_d [NUM_GATES];
  logic [15:0] white_dist_q, white_dist_d;
  logic [15:0] red_dist_q, red_dist_d;
  logic [15:0] blue_dist_q, blue_dist_d;
  logic [15:0] hold_q, hold_d;
  logic        m_valid_q, m_valid_d;
  logic [15:0] m_data_q, m_data_d;

  entry_t      entry_mem [QUEUE_DEPTH];
  entry_t      rdata_q;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t      mem_wdata;

  cmd_e        in_cmd;
  color_e      in_color;
  logic [15:0] dist_sel;
  logic [15:0] hold_eff;
  logic [31:0] cnt_ext;
  logic [4:0]  tracked;

  assign in_cmd        = cmd_e'(s_axis_tuser);
  assign in_color      = color_e'(s_axis_tdata[1:0]);
  assign hold_eff      = (hold_q == 16'd0) ? 16'd1 : hold_q;
  assign cnt_ext       = 32'(cnt_q);
  assign tracked       = (cnt_ext > 32'd31) ? 5'd31 : cnt_ext[4:0];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    case (in_color)
      COL_WHITE: dist_sel = white_dist_q;
      COL_RED:   dist_sel = red_dist_q;
      default:   dist_sel = blue_dist_q;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    click_d      = click_q;
    cnt_d        = cnt_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    rvld_d       = rvld_q;
    rel_d        = rel_q;
    acc_d        = acc_q;
    gate_drv_d   = gate_drv_q;
    gate_tmr_d   = gate_tmr_q;
    white_dist_d = white_dist_q;
    red_dist_d   = red_dist_q;
    blue_dist_d  = blue_dist_q;
    hold_d       = hold_q;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WHITE_DIST: white_dist_d = cfg_data_i;
        REG_RED_DIST:   red_dist_d   = cfg_data_i;
        REG_BLUE_DIST:  blue_dist_d  = cfg_data_i;
        REG_HOLD_TIME:  hold_d       = cfg_data_i;
        default: ;
      endcase
    end

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          acc_d    = 1'b0;
          rel_d    = '0;
          rd_ptr_d = '0;
          wr_ptr_d = '0;
          rvld_d   = 1'b0;
          state_d  = ST_SCAN;
          case (in_cmd)
            CMD_REPORT: begin
              if ((in_color == COL_WHITE || in_color == COL_RED || in_color == COL_BLUE)
                  && (cnt_q < CW'(QUEUE_DEPTH))) begin
                mem_we    = 1'b1;
                mem_waddr = cnt_q[AW-1:0];
                mem_wdata = '{color: in_color, target: click_q + {16'd0, dist_sel}};
                cnt_d     = cnt_q + CW'(1);
                acc_d     = 1'b1;
              end
            end
            CMD_CLICK: click_d = click_q + 32'd1;
            CMD_TICK: begin
              for (int g = 0; g < NUM_GATES; g++) begin
                if (gate_tmr_q[g] != 16'd0) begin
                  gate_tmr_d[g] = gate_tmr_q[g] - 16'd1;
                  if (gate_tmr_q[g] == 16'd1) gate_drv_d[g] = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // read entry rd_ptr while comparing the one fetched last cycle
        if (rd_ptr_q != cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = rd_ptr_q[AW-1:0];
          rd_ptr_d  = rd_ptr_q + CW'(1);
          rvld_d    = 1'b1;
        end else begin
          rvld_d = 1'b0;
        end

        if (rvld_q) begin
          if (click_q >= rdata_q.target) begin
            case (rdata_q.color)
              COL_WHITE, COL_RED, COL_BLUE: begin
                gate_drv_d[rdata_q.color] = 1'b1;
                gate_tmr_d[rdata_q.color] = hold_eff;
                rel_d[rdata_q.color]      = 1'b1;
              end
              default: ;
            endcase
          end else begin
            // compaction: write slot trails the read slot, never collides
            mem_we    = 1'b1;
            mem_waddr = wr_ptr_q[AW-1:0];
            mem_wdata = rdata_q;
            wr_ptr_d  = wr_ptr_q + CW'(1);
          end
        end

        if ((rd_ptr_q == cnt_q) && !rvld_q) begin
          cnt_d   = wr_ptr_q;
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {4'd0, tracked, rel_q, gate_drv_q, acc_q};
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      click_q      <= '0;
      cnt_q        <= '0;
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      rvld_q       <= 1'b0;
      rel_q        <= '0;
      acc_q        <= 1'b0;
      gate_drv_q   <= '0;
      for (int g = 0; g < NUM_GATES; g++) gate_tmr_q[g] <= '0;
      white_dist_q <= WHITE_DIST_RST;
      red_dist_q   <= RED_DIST_RST;
      blue_dist_q  <= BLUE_DIST_RST;
      hold_q       <= HOLD_TIME_RST;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      click_q      <= click_d;
      cnt_q        <= cnt_d;
      rd_ptr_q     <= rd_ptr_d;
      wr_ptr_q     <= wr_ptr_d;
      rvld_q       <= rvld_d;
      rel_q        <= rel_d;
      acc_q        <= acc_d;
      gate_drv_q   <= gate_drv_d;
      gate_tmr_q   <= gate_tmr_d;
      white_dist_q <= white_dist_d;
      red_dist_q   <= red_dist_d;
      blue_dist_q  <= blue_dist_d;
      hold_q       <= hold_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  // queue RAM, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) entry_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= entry_mem[mem_raddr];
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_wr_trails_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (wr_ptr_q <= rd_ptr_q))
    else $error("compaction write overtook the scan read");

  a_gate_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gate_drv_q[0] == (gate_tmr_q[0] != 16'd0)) &&
    (gate_drv_q[1] == (gate_tmr_q[1] != 16'd0)) &&
    (gate_drv_q[2] == (gate_tmr_q[2] != 16'd0)))
    else $error("gate state out of step with its hold timer");
`endif

endmodule

// File: sim/testbench.sv
// Self-checking bench for conveyor_sort_gate_tracker_unit: puck reports, belt clicks
// and ticks under random stalls on both streams, predicted by a gate and queue model.
// Depends on rtl/csgt_pkg.sv and rtl/conveyor_sort_gate_tracker_unit.sv.
`timescale 1ns / 100ps

module testbench;
  import csgt_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 103;
  // codes outside the package enums, used to hit the reject paths
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic [1:0] COL_NONE = 2'd3;

  // lowest bit first: accepted, white, red, blue, released mask, pucks tracked
  typedef struct packed {
    logic [4:0] tracked;
    logic [2:0] released;
    logic       blue_open;
    logic       red_open;
    logic       white_open;
    logic       accepted;
  } gate_result_t;

  class sort_gate_scoreboard;
    logic [15:0]  gate_dist [3];
    logic [15:0]  hold;
    logic [31:0]  clicks;
    logic [31:0]  target_q [$];
    logic [1:0]   colour_q [$];
    logic         gate_drv [3];
    logic [15:0]  gate_timer [3];
    gate_result_t expected_q [$];
    int unsigned  errors, events, results, queued, turned_away;
    int unsigned  releases, closures, peak_fill, settings;

    function new();
      gate_dist = '{WHITE_DIST_RST, RED_DIST_RST, BLUE_DIST_RST};
      hold = HOLD_TIME_RST;
      clicks = '0;
      gate_drv = '{1'b0, 1'b0, 1'b0};
      gate_timer = '{16'd0, 16'd0, 16'd0};
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        REG_WHITE_DIST: gate_dist[0] = value;
        REG_RED_DIST:   gate_dist[1] = value;
        REG_BLUE_DIST:  gate_dist[2] = value;
        REG_HOLD_TIME:  hold = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_event(logic [1:0] cmd, logic [1:0] colour);
      gate_result_t r;
      logic [31:0]  keep_t [$];
      logic [1:0]   keep_c [$];
      r = '0;
      events++;
      case (cmd)
        CMD_REPORT: begin
          if (colour != COL_NONE && target_q.size() < QUEUE_DEPTH) begin
            target_q.push_back(clicks + {16'd0, gate_dist[colour]});
            colour_q.push_back(colour);
            r.accepted = 1'b1;
            queued++;
          end else begin
            turned_away++;
          end
        end
        CMD_CLICK: clicks = clicks + 32'd1;
        CMD_TICK: begin
          for (int g = 0; g < 3; g++) begin
            if (gate_timer[g] != 16'd0) begin
              gate_timer[g] = gate_timer[g] - 16'd1;
              if (gate_timer[g] == 16'd0) begin
                gate_drv[g] = 1'b0;
                closures++;
              end
            end
          end
        end
        default: ;
      endcase
      if (target_q.size() > peak_fill) peak_fill = target_q.size();
      // release scan: reached entries open their gate, the rest keep their order
      foreach (target_q[i]) begin
        if (clicks >= target_q[i]) begin
          gate_drv[colour_q[i]] = 1'b1;
          gate_timer[colour_q[i]] = (hold == 16'd0) ? 16'd1 : hold;
          r.released[colour_q[i]] = 1'b1;
          releases++;
        end else begin
          keep_t.push_back(target_q[i]);
          keep_c.push_back(colour_q[i]);
        end
      end
      target_q = keep_t;
      colour_q = keep_c;
      r.white_open = gate_drv[0];
      r.red_open = gate_drv[1];
      r.blue_open = gate_drv[2];
      r.tracked = 5'(target_q.size());
      expected_q.push_back(r);
    endfunction

    function void compare_field(string field, logic [4:0] want, logic [4:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        errors++;
      end
    endfunction

    function void check_result(logic [15:0] data);
      gate_result_t got, want;
      got = data[11:0];
      if (expected_q.size() == 0) begin
        $error("result transaction with no event outstanding: tdata %h", data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      results++;
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("white_gate_open", want.white_open, got.white_open);
      compare_field("red_gate_open", want.red_open, got.red_open);
      compare_field("blue_gate_open", want.blue_open, got.blue_open);
      compare_field("released_mask", want.released, got.released);
      compare_field("pucks_tracked", want.tracked, got.tracked);
    endfunction

    function void summarise();
      $display("covered %0d events over %0d register settings: %0d reports queued, %0d refused",
               events, settings, queued, turned_away);
      $display("%0d results checked, %0d gate releases, %0d timed closures, queue peak %0d of %0d",
               results, releases, closures, peak_fill, QUEUE_DEPTH);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [1:0] color, rest zero
  logic [1:0]  s_axis_tuser;   // [1:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [0] accepted, [1] white, [2] red, [3] blue,
                               // [6:4] released_mask, [11:7] pucks_tracked

  sort_gate_scoreboard sb = new();
  int unsigned calm_src = 0;
  int unsigned calm_sink = 0;
  int unsigned quiet_cycles = 0;

  conveyor_sort_gate_tracker_unit #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // called just after a rising edge; returns at the edge that accepted the transaction
  task automatic offer_event(input logic [1:0] cmd, input logic [1:0] colour);
    int unsigned gap;
    if (calm_src > 0) begin
      gap = 0;
      calm_src--;
    end else begin
      gap = $urandom_range(0, 18);
      if ($urandom_range(0, 24) == 0) calm_src = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {6'd0, colour};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_event(cmd, colour);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [15:0] w, input logic [15:0] r,
                               input logic [15:0] b, input logic [15:0] h);
    logic [1:0]  idx [4];
    logic [15:0] vals [4];
    idx = '{REG_WHITE_DIST, REG_RED_DIST, REG_BLUE_DIST, REG_HOLD_TIME};
    vals = '{w, r, b, h};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(idx[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
    sb.settings++;
  endtask

  // mostly reports and clicks, some ticks, a little noise
  task automatic random_event(output logic [1:0] cmd, output logic [1:0] colour);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) cmd = CMD_NONE;
    else if (roll < 33) cmd = CMD_REPORT;
    else if (roll < 72) cmd = CMD_CLICK;
    else cmd = CMD_TICK;
    colour = ($urandom_range(0, 19) == 0) ? COL_NONE : 2'($urandom_range(0, 2));
  endtask

  // result side: random stall before each transaction, with calm stretches
  initial begin
    int unsigned gap;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (calm_sink > 0) begin
        gap = 0;
        calm_sink--;
      end else begin
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 24) == 0) calm_sink = $urandom_range(8, 40);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      sb.check_result(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("conveyor_sort_gate_tracker_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [1:0]  cmd, colour;
    logic [15:0] w, r, b, h;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_WHITE_DIST;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= CMD_REPORT;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: bad colour, unused command, idle tick, overfill the queue, then a click and a tick
    offer_event(CMD_REPORT, COL_NONE);
    offer_event(CMD_NONE, COL_BLUE);
    offer_event(CMD_TICK, COL_WHITE);
    for (int i = 0; i <= QUEUE_DEPTH; i++) offer_event(CMD_REPORT, 2'(i % 3));
    offer_event(CMD_CLICK, COL_NONE);
    offer_event(CMD_TICK, COL_RED);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        // zero distance releases at once, zero hold behaves as one tick
        w = 16'd0; r = 16'd1; b = 16'd2; h = 16'd0;
      end else if (p == PHASES - 2) begin
        w = 16'd0; r = 16'hFFFF; b = 16'd1; h = 16'hFFFF;
      end else if (p == PHASES - 1) begin
        w = 16'($urandom); r = 16'($urandom); b = 16'($urandom); h = 16'($urandom);
      end else if (p % 3 == 0) begin
        w = 16'($urandom_range(0, 6)); r = 16'($urandom_range(0, 6));
        b = 16'($urandom_range(0, 6)); h = 16'($urandom_range(0, 8));
      end else if (p % 3 == 1) begin
        w = 16'($urandom_range(0, 40)); r = 16'($urandom_range(0, 40));
        b = 16'($urandom_range(0, 40)); h = 16'($urandom_range(1, 60));
      end else begin
        w = WHITE_DIST_RST; r = RED_DIST_RST; b = BLUE_DIST_RST; h = HOLD_TIME_RST;
      end
      load_settings(w, r, b, h);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_event(cmd, colour);
        offer_event(cmd, colour);
      end
      drain();
    end

    repeat (QUEUE_DEPTH + 8) @(posedge clk_i);
    sb.summarise();
    if (sb.errors == 0) begin
      $display("conveyor_sort_gate_tracker_unit verification clean");
    end else begin
      $display("conveyor_sort_gate_tracker_unit verification failed");
    end
    $finish;
  end

endmodule
